[rtl/lstk_pkg.sv]
// ----------------------------------------------------------------------------
// LIFO stack package
// Shared sizes, command, status and edit kind codes, and the edit and result structs.
// ----------------------------------------------------------------------------
package lstk_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int CMD_W   = 3;
   localparam int POS_W   = 5;
   localparam int CAP_W   = 5;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 48;
   localparam int RSP_USED_W = STAT_W + WORD_W + COUNT_W + 2;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
   localparam logic [WORD_W-1:0] EMPTY_TOP = 32'h8000_0000;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH     = 3'd0,
      CMD_POP      = 3'd1,
      CMD_PEEK     = 3'd2,
      CMD_CLEAR    = 3'd3,
      CMD_INS_BOT  = 3'd4,
      CMD_REM_BOT  = 3'd5,
      CMD_REM_POS  = 3'd6,
      CMD_REVERSE  = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_BADPOS   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EDIT_NONE = 2'd0,
      EDIT_INS  = 2'd1,
      EDIT_DEL  = 2'd2
   } edit_kind_type;

   typedef struct packed {
      edit_kind_type     kind;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] value;
   } edit_type;

   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] cnt;
      logic             rev;
      logic             full;
   } result_type;

endpackage

[rtl/lifo_stack_with_edit_ops.sv]
// ----------------------------------------------------------------------------
// LIFO stack with edit commands
// Bounded stack of signed words held in a row of cells, with push, pop, peek,
// clear, bottom insert and remove, remove at position and reverse.
// An accepted item's result reaches the output register in the next cycle.
// One item per cycle unless a result waits on rsp_tready; edits update cells at once.
// Reset: count zero, capacity limit 16, output register empty; words undefined.
// ----------------------------------------------------------------------------
module lifo_stack_with_edit_ops
   import lstk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // cmd[2:0], value[34:3], position[39:35]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status[1:0], top_value[33:2], count[38:34], is_empty[39], is_full[40], zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_wen,
   input  logic [CAP_W-1:0] csr_wdata
);

   logic              fire;
   logic [CAP_W-1:0]  cap_ff;
   edit_type          edit;
   result_type        result;
   logic [WORD_W-1:0] cur_data [DEPTH];
   logic [WORD_W-1:0] nxt_data [DEPTH];
   logic [WORD_W-1:0] top_value;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wen) begin
         cap_ff <= csr_wdata;
      end
   end

   lstk_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .cmd      (cmd_type'(req_tdata[CMD_W-1:0])),
      .value    (req_tdata[CMD_W +: WORD_W]),
      .position (req_tdata[CMD_W+WORD_W +: POS_W]),
      .cap      (cap_ff),
      .edit     (edit),
      .result   (result)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      lstk_cell u_cell (
         .clock      (clock),
         .edit       (edit),
         .slot       (IDX_W'(i)),
         .lower_data ((i == 0) ? edit.value : cur_data[(i == 0) ? 0 : i - 1]),
         .upper_data ((i == DEPTH - 1) ? cur_data[i] : cur_data[(i == DEPTH - 1) ? i : i + 1]),
         .data       (cur_data[i]),
         .data_next  (nxt_data[i])
      );
   end

   always_comb begin
      if (result.cnt == '0) begin
         top_value = EMPTY_TOP;
      end else if (result.rev) begin
         top_value = nxt_data[0];
      end else begin
         top_value = nxt_data[IDX_W'(result.cnt - CNT_W'(1))];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_W - RSP_USED_W){1'b0}}, result.full, result.cnt == '0,
                         COUNT_W'(result.cnt), top_value, result.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("accepted item gave no result");

   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39] == (rsp_tdata[38:34] == '0)))
      else $error("empty flag disagrees with count");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[38:34]) <= DEPTH))
      else $error("count beyond depth");

   a_empty_top : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[39]) |-> (rsp_tdata[33:2] == EMPTY_TOP))
      else $error("empty stack shows a top word");

endmodule

[rtl/lstk_cell.sv]
// ----------------------------------------------------------------------------
// LIFO stack cell
// One stack word: hold, load the new word, or take a neighbour's word.
// ----------------------------------------------------------------------------
module lstk_cell
   import lstk_pkg::*;
(
   input  logic              clock,
   input  edit_type          edit,
   input  logic [IDX_W-1:0]  slot,
   input  logic [WORD_W-1:0] lower_data,
   input  logic [WORD_W-1:0] upper_data,
   output logic [WORD_W-1:0] data,
   output logic [WORD_W-1:0] data_next
);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (edit.kind)
         EDIT_INS: begin
            if (slot == edit.idx) begin
               data_in = edit.value;
            end else if (slot > edit.idx) begin
               data_in = lower_data;
            end
         end
         EDIT_DEL: begin
            if (slot >= edit.idx) begin
               data_in = upper_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign data_next = data_in;

endmodule

[rtl/lstk_ctrl.sv]
// ----------------------------------------------------------------------------
// LIFO stack control
// Count and orientation registers; turn each command into a status and any row edit.
// ----------------------------------------------------------------------------
module lstk_ctrl
   import lstk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  cmd_type           cmd,
   input  logic [WORD_W-1:0] value,
   input  logic [POS_W-1:0]  position,
   input  logic [CAP_W-1:0]  cap,
   output edit_type          edit,
   output result_type        result
);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rev_ff, rev_in;
   logic [CNT_W-1:0] cap_eff;
   logic             full;
   logic             empty;
   logic             pos_ok;
   logic [31:0]      del_idx;
   status_type       status;
   edit_kind_type    kind;
   logic [IDX_W-1:0] idx;

   always_comb begin
      if (cap == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap) > DEPTH) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap);
      end
   end

   assign full    = cnt_ff >= cap_eff;
   assign empty   = cnt_ff == '0;
   assign pos_ok  = (position != '0) && (32'(position) <= 32'(cnt_ff));
   assign del_idx = rev_ff ? (32'(cnt_ff) - 32'(position)) : (32'(position) - 32'd1);

   always_comb begin
      status = ST_OK;
      kind   = EDIT_NONE;
      idx    = '0;
      cnt_in = cnt_ff;
      rev_in = rev_ff;
      case (cmd)
         CMD_PUSH, CMD_INS_BOT: begin
            if (full) begin
               status = ST_OVERFLOW;
            end else begin
               kind   = EDIT_INS;
               idx    = ((cmd == CMD_PUSH) != rev_ff) ? cnt_ff[IDX_W-1:0] : '0;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         CMD_POP, CMD_REM_BOT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               kind   = ((cmd == CMD_POP) == rev_ff) ? EDIT_DEL : EDIT_NONE;
               idx    = '0;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         CMD_PEEK: begin
            if (empty) begin
               status = ST_EMPTY;
            end
         end
         CMD_CLEAR: begin
            cnt_in = '0;
            rev_in = 1'b0;
         end
         CMD_REM_POS: begin
            if (!pos_ok) begin
               status = ST_BADPOS;
            end else begin
               kind   = EDIT_DEL;
               idx    = del_idx[IDX_W-1:0];
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         CMD_REVERSE: begin
            rev_in = !rev_ff;
         end
         default: status = ST_OK;
      endcase
      if (!fire) begin
         kind   = EDIT_NONE;
         cnt_in = cnt_ff;
         rev_in = rev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rev_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rev_ff <= rev_in;
      end
   end

   assign edit.kind   = kind;
   assign edit.idx    = idx;
   assign edit.value  = value;
   assign result.status = status;
   assign result.cnt    = cnt_in;
   assign result.rev    = rev_in;
   assign result.full   = cnt_in >= cap_eff;

endmodule
